>>> sv/vcb_pkg.sv
// ----------------------------------------------------------------------------
// vcb_pkg
// Shared types and fixed constants for the streaming valid 2-D convolution.
// ----------------------------------------------------------------------------
package vcb_pkg;

    // Field widths fixed by the interface
    localparam int PIX_W      = 16;
    localparam int WIDX_W     = 4;
    localparam int ROWCOL_W   = 8;
    localparam int RES_W      = 48;
    localparam int CFG_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_SIZE_W = 9;

    // Datapath widths: 16x16 product, row sum of up to 8, total of up to 64 plus bias
    localparam int PROD_W = 32;
    localparam int RSUM_W = 35;
    localparam int ACC_W  = 50;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Request operations
    localparam logic OP_PIXEL  = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS = 2'd2;

    // Saturation limits
    localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    // One classified request as it travels through the queue
    typedef struct packed {
        logic                op;
        logic [PIX_W-1:0]    data;
        logic [WIDX_W-1:0]   widx;
        logic                emit;
        logic [ROWCOL_W-1:0] out_row;
        logic [ROWCOL_W-1:0] out_col;
        logic                last;
    } vcb_cmd_t;

    // Position tag carried beside a result through the MAC pipeline
    typedef struct packed {
        logic [ROWCOL_W-1:0] out_row;
        logic [ROWCOL_W-1:0] out_col;
        logic                last;
    } vcb_meta_t;

endpackage

>>> sv/valid_conv2d_with_bias.sv
// ----------------------------------------------------------------------------
// valid_conv2d_with_bias
// Result path: queue, line-store stage, window, products, row sums, output.
// Throughput: one request (pixel or weight load) per cycle unless the output
// stalls; one line-store RAM read and write per pixel, fully pipelined MAC.
// Reset: counters, queue, weights and pipeline valids clear; size registers
// return to 256 (clamped to the maximum) and bias to zero.
// ----------------------------------------------------------------------------
module valid_conv2d_with_bias #(
    parameter int KERNEL_ROWS = 3,
    parameter int KERNEL_COLS = 3,
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLS    = 256
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_operation,
    input  logic signed [vcb_pkg::PIX_W-1:0]        s_pixel,
    input  logic [vcb_pkg::WIDX_W-1:0]              s_weight_index,
    input  logic signed [vcb_pkg::PIX_W-1:0]        s_weight,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [vcb_pkg::RES_W-1:0]        m_result,
    output logic [vcb_pkg::ROWCOL_W-1:0]            m_out_row,
    output logic [vcb_pkg::ROWCOL_W-1:0]            m_out_col,
    output logic                                    m_last,
    input  logic                                    cfg_we,
    input  logic [vcb_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [vcb_pkg::CFG_W-1:0]               cfg_wdata
);
    import vcb_pkg::*;

    localparam int ROW_LIM_MAX = (MAX_ROWS > KERNEL_ROWS) ? MAX_ROWS : KERNEL_ROWS;
    localparam int COL_LIM_MAX = (MAX_COLS > KERNEL_COLS) ? MAX_COLS : KERNEL_COLS;
    localparam int CW  = $clog2(COL_LIM_MAX);
    localparam int RLW = $clog2(ROW_LIM_MAX + 1);
    localparam int CLW = $clog2(COL_LIM_MAX + 1);
    localparam int RST_ROWS = (256 > MAX_ROWS) ? MAX_ROWS : 256;
    localparam int RST_COLS = (256 > MAX_COLS) ? MAX_COLS : 256;

    logic [RLW-1:0]          rows_lim_reg, rows_clamp;
    logic [CLW-1:0]          cols_lim_reg, cols_clamp;
    logic signed [RES_W-1:0] bias_reg;
    logic [CFG_SIZE_W-1:0]   cfg_size;

    logic                    q_valid;
    logic                    q_pop;
    vcb_cmd_t                q_cmd;
    logic [CW-1:0]           q_col;

    // Image sizes are held already clamped to the kernel and the maximum
    always_comb begin
        cfg_size = cfg_wdata[CFG_SIZE_W-1:0];
        if (32'(cfg_size) < 32'(KERNEL_ROWS)) begin
            rows_clamp = RLW'(KERNEL_ROWS);
        end else if (32'(cfg_size) > 32'(MAX_ROWS)) begin
            rows_clamp = RLW'(MAX_ROWS);
        end else begin
            rows_clamp = RLW'(cfg_size);
        end
        if (32'(cfg_size) < 32'(KERNEL_COLS)) begin
            cols_clamp = CLW'(KERNEL_COLS);
        end else if (32'(cfg_size) > 32'(MAX_COLS)) begin
            cols_clamp = CLW'(MAX_COLS);
        end else begin
            cols_clamp = CLW'(cfg_size);
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_lim_reg <= RLW'(RST_ROWS);
            cols_lim_reg <= CLW'(RST_COLS);
            bias_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ROWS: rows_lim_reg <= rows_clamp;
                CFG_COLS: cols_lim_reg <= cols_clamp;
                CFG_BIAS: bias_reg     <= cfg_wdata[RES_W-1:0];
                default:  ;
            endcase
        end
    end

    vcb_front #(
        .KERNEL_ROWS (KERNEL_ROWS),
        .KERNEL_COLS (KERNEL_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_pixel        (s_pixel),
        .s_weight_index (s_weight_index),
        .s_weight       (s_weight),
        .rows_lim       (rows_lim_reg),
        .cols_lim       (cols_lim_reg),
        .q_pop          (q_pop),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_col          (q_col)
    );

    vcb_back #(
        .KERNEL_ROWS (KERNEL_ROWS),
        .KERNEL_COLS (KERNEL_COLS),
        .MAX_COLS    (MAX_COLS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .q_col     (q_col),
        .bias      (bias_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .m_out_row (m_out_row),
        .m_out_col (m_out_col),
        .m_last    (m_last)
    );

`ifndef NO_ASSERTIONS
    a_rows_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (rows_lim_reg <= RLW'(ROW_LIM_MAX)) && (cols_lim_reg <= CLW'(COL_LIM_MAX)))
        else $error("image size register out of range");

    a_cfg_bias: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_we && (cfg_index == CFG_BIAS)) |=> (bias_reg == $past(cfg_wdata[RES_W-1:0])))
        else $error("bias write lost");

    a_cfg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_we |=> ($stable(rows_lim_reg) && $stable(cols_lim_reg) && $stable(bias_reg)))
        else $error("configuration changed without a write");
`endif

endmodule

>>> sv/vcb_ram.sv
// ----------------------------------------------------------------------------
// vcb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vcb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port; read returns old data on a same-address collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/vcb_front.sv
// ----------------------------------------------------------------------------
// vcb_front
// Accepts requests, tracks the raster position, tags each pixel with its
// output position and pushes the request into a short command queue.
// ----------------------------------------------------------------------------
module vcb_front #(
    parameter int KERNEL_ROWS = 3,
    parameter int KERNEL_COLS = 3,
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLS    = 256
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_operation,
    input  logic signed [vcb_pkg::PIX_W-1:0]        s_pixel,
    input  logic [vcb_pkg::WIDX_W-1:0]              s_weight_index,
    input  logic signed [vcb_pkg::PIX_W-1:0]        s_weight,
    input  logic [$clog2((MAX_ROWS > KERNEL_ROWS ? MAX_ROWS : KERNEL_ROWS)+1)-1:0] rows_lim,
    input  logic [$clog2((MAX_COLS > KERNEL_COLS ? MAX_COLS : KERNEL_COLS)+1)-1:0] cols_lim,
    input  logic                                    q_pop,
    output logic                                    q_valid,
    output vcb_pkg::vcb_cmd_t                       q_cmd,
    output logic [$clog2(MAX_COLS > KERNEL_COLS ? MAX_COLS : KERNEL_COLS)-1:0] q_col
);
    import vcb_pkg::*;

    localparam int ROW_LIM_MAX = (MAX_ROWS > KERNEL_ROWS) ? MAX_ROWS : KERNEL_ROWS;
    localparam int COL_LIM_MAX = (MAX_COLS > KERNEL_COLS) ? MAX_COLS : KERNEL_COLS;
    localparam int RW  = $clog2(ROW_LIM_MAX);
    localparam int CW  = $clog2(COL_LIM_MAX);
    localparam int RLW = $clog2(ROW_LIM_MAX + 1);
    localparam int CLW = $clog2(COL_LIM_MAX + 1);

    logic [RW-1:0]     row_count_reg, row_count_next;
    logic [CW-1:0]     col_count_reg, col_count_next;
    logic [RW-1:0]     row_cur;
    logic [CW-1:0]     col_cur;
    logic              col_wrap, row_wrap;
    vcb_cmd_t          cmd;
    logic              push;

    vcb_cmd_t          q_cmd_reg [QUEUE_DEPTH];
    logic [CW-1:0]     q_col_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;

    // Raster position of this pixel; a stale counter after a resize restarts at zero
    always_comb begin
        row_cur  = (RLW'(row_count_reg) >= rows_lim) ? '0 : row_count_reg;
        col_cur  = (CLW'(col_count_reg) >= cols_lim) ? '0 : col_count_reg;
        col_wrap = (CLW'(col_cur) + CLW'(1)) >= cols_lim;
        row_wrap = (RLW'(row_cur) + RLW'(1)) >= rows_lim;

        cmd.op      = s_operation;
        cmd.data    = (s_operation == OP_WEIGHT) ? s_weight : s_pixel;
        cmd.widx    = s_weight_index;
        cmd.emit    = (32'(row_cur) >= 32'(KERNEL_ROWS - 1)) &&
                      (32'(col_cur) >= 32'(KERNEL_COLS - 1));
        cmd.out_row = ROWCOL_W'(32'(row_cur) - 32'(KERNEL_ROWS - 1));
        cmd.out_col = ROWCOL_W'(32'(col_cur) - 32'(KERNEL_COLS - 1));
        cmd.last    = col_wrap && row_wrap;

        if (col_wrap) begin
            col_count_next = '0;
            row_count_next = row_wrap ? '0 : row_cur + RW'(1);
        end else begin
            col_count_next = col_cur + CW'(1);
            row_count_next = row_cur;
        end
    end

    // Position counters move on pixels only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end else if (push && (s_operation == OP_PIXEL)) begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // Queue pointers and fill count
    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        case ({push, q_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_cmd_reg[wr_ptr_reg] <= cmd;
            q_col_reg[wr_ptr_reg] <= col_cur;
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_cmd   = q_cmd_reg[rd_ptr_reg];
    assign q_col   = q_col_reg[rd_ptr_reg];

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue overfilled");

    a_count_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !q_pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue count missed a push");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && (count_reg == QCNT_W'(1)) && !push) |=> !q_valid)
        else $error("queue not empty after last pop");
`endif

endmodule

>>> sv/vcb_back.sv
// ----------------------------------------------------------------------------
// vcb_back
// Executes queued requests in order: line store and window update, weight
// loads, then a multiply, row-sum, total-plus-bias pipeline into the output.
// ----------------------------------------------------------------------------
module vcb_back #(
    parameter int KERNEL_ROWS = 3,
    parameter int KERNEL_COLS = 3,
    parameter int MAX_COLS    = 256
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    q_valid,
    output logic                                    q_pop,
    input  vcb_pkg::vcb_cmd_t                       q_cmd,
    input  logic [$clog2(MAX_COLS > KERNEL_COLS ? MAX_COLS : KERNEL_COLS)-1:0] q_col,
    input  logic signed [vcb_pkg::RES_W-1:0]        bias,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [vcb_pkg::RES_W-1:0]        m_result,
    output logic [vcb_pkg::ROWCOL_W-1:0]            m_out_row,
    output logic [vcb_pkg::ROWCOL_W-1:0]            m_out_col,
    output logic                                    m_last
);
    import vcb_pkg::*;

    localparam int COL_LIM_MAX = (MAX_COLS > KERNEL_COLS) ? MAX_COLS : KERNEL_COLS;
    localparam int CW    = $clog2(COL_LIM_MAX);
    localparam int LINES = KERNEL_ROWS - 1;
    localparam int KSIZE = KERNEL_ROWS * KERNEL_COLS;
    localparam int LW    = (LINES > 0) ? PIX_W * LINES : PIX_W;

    logic                      back_en;
    logic                      s1_valid_reg;
    vcb_cmd_t                  s1_cmd_reg;
    logic [CW-1:0]             s1_col_reg;
    logic [LW-1:0]             ram_rdata;
    logic [LW-1:0]             line_cur;
    logic [LW-1:0]             line_wdata;
    logic [PIX_W*KERNEL_ROWS-1:0] col_vec;
    logic                      line_we;
    logic                      byp_hit_reg;
    logic [LW-1:0]             byp_data_reg;

    logic signed [PIX_W-1:0]   win_reg [KERNEL_ROWS][KERNEL_COLS];
    logic signed [PIX_W-1:0]   wgt_reg [KSIZE];

    logic                      s2_valid_reg, s3_valid_reg, s4_valid_reg;
    vcb_meta_t                 s2_meta_reg, s3_meta_reg, s4_meta_reg;
    logic signed [PROD_W-1:0]  prod_reg [KSIZE];
    logic signed [RSUM_W-1:0]  rsum_reg [KERNEL_ROWS];
    logic signed [RSUM_W-1:0]  rsum_next [KERNEL_ROWS];
    logic signed [ACC_W-1:0]   acc;
    logic [RES_W-1:0]          sat;
    logic                      ovf;

    logic                      m_valid_reg;
    logic [RES_W-1:0]          m_result_reg;
    vcb_meta_t                 m_meta_reg;

    // Whole back pipeline advances when the output register can take a result
    assign back_en = !m_valid_reg || m_ready;
    assign q_pop   = back_en && q_valid;
    assign line_we = back_en && s1_valid_reg && (s1_cmd_reg.op == OP_PIXEL);

    // Line store: one RAM word holds a column of the buffered rows
    generate
        if (LINES > 0) begin : g_lines
            vcb_ram #(
                .WIDTH (LW),
                .DEPTH (COL_LIM_MAX)
            ) u_line_ram (
                .aclk  (aclk),
                .we    (line_we),
                .waddr (s1_col_reg),
                .wdata (line_wdata),
                .re    (q_pop),
                .raddr (q_col),
                .rdata (ram_rdata)
            );
            assign col_vec    = {s1_cmd_reg.data, line_cur};
            assign line_wdata = col_vec[PIX_W*KERNEL_ROWS-1:PIX_W];
        end else begin : g_nolines
            assign ram_rdata  = '0;
            assign col_vec    = s1_cmd_reg.data;
            assign line_wdata = '0;
        end
    endgenerate

    // Forward a write that landed on the column read at the same edge
    assign line_cur = byp_hit_reg ? byp_data_reg : ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end else if (back_en) begin
            s1_valid_reg <= q_valid;
            byp_hit_reg  <= q_valid && line_we && (s1_col_reg == q_col);
        end
    end

    always_ff @(posedge aclk) begin
        if (back_en) begin
            s1_cmd_reg   <= q_cmd;
            s1_col_reg   <= q_col;
            byp_data_reg <= line_wdata;
        end
    end

    // Window shift on pixels
    always_ff @(posedge aclk) begin
        if (back_en && s1_valid_reg && (s1_cmd_reg.op == OP_PIXEL)) begin
            for (int r = 0; r < KERNEL_ROWS; r++) begin
                for (int c = 0; c + 1 < KERNEL_COLS; c++) begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
                win_reg[r][KERNEL_COLS-1] <= col_vec[r*PIX_W +: PIX_W];
            end
        end
    end

    // Kernel weights; an index past the kernel is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KSIZE; k++) begin
                wgt_reg[k] <= '0;
            end
        end else if (back_en && s1_valid_reg && (s1_cmd_reg.op == OP_WEIGHT)) begin
            for (int k = 0; k < KSIZE; k++) begin
                if (32'(s1_cmd_reg.widx) == 32'(k)) begin
                    wgt_reg[k] <= s1_cmd_reg.data;
                end
            end
        end
    end

    // Row sums and total with saturation
    always_comb begin
        for (int r = 0; r < KERNEL_ROWS; r++) begin
            rsum_next[r] = '0;
            for (int c = 0; c < KERNEL_COLS; c++) begin
                rsum_next[r] = rsum_next[r] + RSUM_W'(prod_reg[r*KERNEL_COLS + c]);
            end
        end
        acc = ACC_W'(bias);
        for (int r = 0; r < KERNEL_ROWS; r++) begin
            acc = acc + ACC_W'(rsum_reg[r]);
        end
        ovf = !((&acc[ACC_W-1:RES_W-1]) || !(|acc[ACC_W-1:RES_W-1]));
        sat = ovf ? (acc[ACC_W-1] ? RES_MIN : RES_MAX) : acc[RES_W-1:0];
    end

    // Pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (back_en) begin
            s2_valid_reg <= s1_valid_reg && (s1_cmd_reg.op == OP_PIXEL) && s1_cmd_reg.emit;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= s4_valid_reg;
        end
    end

    // Pipeline payload: products, row sums, result
    always_ff @(posedge aclk) begin
        if (back_en) begin
            s2_meta_reg.out_row <= s1_cmd_reg.out_row;
            s2_meta_reg.out_col <= s1_cmd_reg.out_col;
            s2_meta_reg.last    <= s1_cmd_reg.last;
            for (int r = 0; r < KERNEL_ROWS; r++) begin
                for (int c = 0; c < KERNEL_COLS; c++) begin
                    prod_reg[r*KERNEL_COLS + c] <= PROD_W'(win_reg[r][c]) *
                                                   PROD_W'(wgt_reg[r*KERNEL_COLS + c]);
                end
            end
            s3_meta_reg <= s2_meta_reg;
            for (int r = 0; r < KERNEL_ROWS; r++) begin
                rsum_reg[r] <= rsum_next[r];
            end
            s4_meta_reg  <= s3_meta_reg;
            m_result_reg <= sat;
            m_meta_reg   <= s4_meta_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_result  = m_result_reg;
    assign m_out_row = m_meta_reg.out_row;
    assign m_out_col = m_meta_reg.out_col;
    assign m_last    = m_meta_reg.last;

`ifndef NO_ASSERTIONS
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=>
            ($stable(s2_valid_reg) && $stable(s3_valid_reg) && $stable(s4_valid_reg)))
        else $error("MAC pipeline moved during output stall");

    a_bypass_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        byp_hit_reg |-> s1_valid_reg)
        else $error("line bypass without a request in flight");

    a_no_pop_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !q_pop)
        else $error("queue popped while output stalled");
`endif

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: streaming valid 2-D convolution with bias
// A driver and a monitor run as clocked processes around the block. Every
// accepted request updates a behavioral copy of the window, line store and
// kernel, which queues the window sum it expects; the monitor compares each
// result field by field. Sizes and bias are set between drained phases.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vcb_pkg::*;

    localparam int KR = 3;
    localparam int KC = 3;
    localparam int MR = 256;
    localparam int MC = 256;
    localparam int PHASE_PAD = 12;
    localparam int END_PAD = 20;
    localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct {
        logic                      op;
        logic signed [PIX_W-1:0]   pixel;
        logic [WIDX_W-1:0]         widx;
        logic signed [PIX_W-1:0]   weight;
    } conv_req_t;

    typedef struct {
        logic signed [RES_W-1:0]   value;
        logic [ROWCOL_W-1:0]       row;
        logic [ROWCOL_W-1:0]       col;
        logic                      last;
    } conv_out_t;

    // Clock, reset and block ports
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_operation = OP_PIXEL;
    logic signed [PIX_W-1:0] s_pixel = '0;
    logic [WIDX_W-1:0] s_weight_index = '0;
    logic signed [PIX_W-1:0] s_weight = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [RES_W-1:0] m_result;
    logic [ROWCOL_W-1:0] m_out_row;
    logic [ROWCOL_W-1:0] m_out_col;
    logic m_last;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // Stimulus control
    conv_req_t pixel_stream[$];
    conv_req_t cur_req;
    conv_out_t sums_due[$];
    logic idle_on = 1'b0;
    logic stall_arm = 1'b0;
    logic rx_hold = 1'b0;
    int tx_gap = 0;
    int rx_gap = 0;

    // Bookkeeping
    int n_queued = 0;
    int n_accepted = 0;
    int n_pixels = 0;
    int n_loads = 0;
    int n_results = 0;
    int n_frames = 0;
    int n_saturated = 0;
    int n_settings = 0;
    int n_errors = 0;

    // Behavioral copy of the convolver state
    logic [CFG_SIZE_W-1:0] size_rows = 9'd256;
    logic [CFG_SIZE_W-1:0] size_cols = 9'd256;
    logic signed [RES_W-1:0] bias_reg = '0;
    logic signed [PIX_W-1:0] line_mem [KR-1][MC] = '{default: '0};
    logic signed [PIX_W-1:0] win [KR][KC] = '{default: '0};
    logic signed [PIX_W-1:0] kern [KR*KC] = '{default: '0};
    int row_pos = 0;
    int col_pos = 0;

    valid_conv2d_with_bias #(
        .KERNEL_ROWS(KR),
        .KERNEL_COLS(KC),
        .MAX_ROWS(MR),
        .MAX_COLS(MC)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_pixel(s_pixel),
        .s_weight_index(s_weight_index),
        .s_weight(s_weight),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result(m_result),
        .m_out_row(m_out_row),
        .m_out_col(m_out_col),
        .m_last(m_last),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #1 aclk = ~aclk;

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        n_errors++;
    endtask

    function automatic int clamp_dim(logic [CFG_SIZE_W-1:0] v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // Shift one pixel into the window and line store; queue the window sum
    // whenever the window lies fully inside the image.
    function automatic void convolve_pixel(logic signed [PIX_W-1:0] px);
        int rows;
        int cols;
        int row;
        int col;
        longint acc;
        conv_out_t res;
        rows = clamp_dim(size_rows, KR, MR);
        cols = clamp_dim(size_cols, KC, MC);
        row = row_pos;
        col = col_pos;
        // stale counters after a size change wrap to zero
        if (col >= cols) col = 0;
        if (row >= rows) row = 0;
        for (int r = 0; r < KR; r++) begin
            for (int c = 0; c < KC - 1; c++) win[r][c] = win[r][c+1];
            win[r][KC-1] = (r < KR - 1) ? line_mem[r][col] : px;
        end
        for (int r = 0; r < KR - 2; r++) line_mem[r][col] = line_mem[r+1][col];
        line_mem[KR-2][col] = px;
        if (row + 1 >= KR && col + 1 >= KC) begin
            acc = longint'(bias_reg);
            for (int r = 0; r < KR; r++) begin
                for (int c = 0; c < KC; c++) begin
                    acc += longint'(win[r][c]) * longint'(kern[r*KC+c]);
                end
            end
            if (acc > SAT_HI) begin
                acc = SAT_HI;
                n_saturated++;
            end else if (acc < SAT_LO) begin
                acc = SAT_LO;
                n_saturated++;
            end
            res.value = acc[RES_W-1:0];
            res.row = ROWCOL_W'(row + 1 - KR);
            res.col = ROWCOL_W'(col + 1 - KC);
            res.last = (col + 1 >= cols) && (row + 1 >= rows);
            sums_due.push_back(res);
        end
        if (col + 1 >= cols) begin
            col_pos = 0;
            row_pos = (row + 1 >= rows) ? 0 : row + 1;
        end else begin
            col_pos = col + 1;
            row_pos = row;
        end
    endfunction

    function automatic logic signed [PIX_W-1:0] pick16();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($urandom_range(0, 8) - 4);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [RES_W-1:0] pick_bias();
        case ($urandom_range(0, 4))
            0: return RES_MAX;
            1: return RES_MIN;
            2: return RES_W'(longint'($urandom_range(0, 2000)) - 1000);
            default: return RES_W'({$urandom(), $urandom()});
        endcase
    endfunction

    function automatic void push_req(logic op, logic signed [PIX_W-1:0] px,
                                     logic [WIDX_W-1:0] idx, logic signed [PIX_W-1:0] w);
        conv_req_t q;
        q.op = op;
        q.pixel = px;
        q.widx = idx;
        q.weight = w;
        pixel_stream.push_back(q);
        n_queued++;
    endfunction

    // Random pixels with a weight load sprinkled in about once per load_one_in
    function automatic void queue_pixels(int npix, int load_one_in);
        logic [WIDX_W-1:0] idx;
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(1, load_one_in) == 1) begin
                idx = ($urandom_range(0, 4) == 0) ? WIDX_W'($urandom_range(9, 15))
                                                  : WIDX_W'($urandom_range(0, 8));
                push_req(OP_WEIGHT, 16'($urandom()), idx, pick16());
            end
            push_req(OP_PIXEL, pick16(), WIDX_W'($urandom()), 16'($urandom()));
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ROWS: size_rows = data[CFG_SIZE_W-1:0];
            CFG_COLS: size_cols = data[CFG_SIZE_W-1:0];
            CFG_BIAS: bias_reg = data;
            default: ;
        endcase
    endtask

    task automatic configure(int rows, int cols, logic [CFG_W-1:0] bias_v);
        write_reg(CFG_ROWS, CFG_W'(rows));
        write_reg(CFG_COLS, CFG_W'(cols));
        write_reg(CFG_BIAS, bias_v);
        n_settings++;
    endtask

    // Wait until every queued request is taken and every sum has come back
    task automatic drain(int pad);
        while (n_accepted != n_queued) @(posedge aclk);
        while (sums_due.size() != 0) @(posedge aclk);
        repeat (pad) @(posedge aclk);
    endtask

    // Request driver
    always @(posedge aclk) begin : request_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (cur_req.op == OP_WEIGHT) begin
                    if (cur_req.widx < KR * KC) kern[cur_req.widx] = cur_req.weight;
                    n_loads++;
                end else begin
                    convolve_pixel(cur_req.pixel);
                    n_pixels++;
                end
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (idle_on && pixel_stream.size() != 0
                             && $urandom_range(0, 6) == 0) begin
                    tx_gap = $urandom_range(0, 7);
                    s_valid <= 1'b0;
                end else if (pixel_stream.size() != 0) begin
                    cur_req = pixel_stream.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= cur_req.op;
                    s_pixel <= cur_req.pixel;
                    s_weight_index <= cur_req.widx;
                    s_weight <= cur_req.weight;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge aclk) begin : result_monitor
        conv_out_t due;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (sums_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d at row %0d col %0d",
                                              m_result, m_out_row, m_out_col));
                end else begin
                    due = sums_due.pop_front();
                    if (m_result !== due.value)
                        report_mismatch($sformatf("result %0d, expected %0d (row %0d col %0d)",
                                                  m_result, due.value, due.row, due.col));
                    if (m_out_row !== due.row)
                        report_mismatch($sformatf("out_row %0d, expected %0d",
                                                  m_out_row, due.row));
                    if (m_out_col !== due.col)
                        report_mismatch($sformatf("out_col %0d, expected %0d",
                                                  m_out_col, due.col));
                    if (m_last !== due.last)
                        report_mismatch($sformatf("last %b, expected %b at row %0d col %0d",
                                                  m_last, due.last, due.row, due.col));
                    n_results++;
                    if (due.last) n_frames++;
                end
            end
            if (rx_hold) begin
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial begin : long_result_stall
        wait (stall_arm);
        repeat (60) @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin : run_limit
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : main_sequence
        logic [CFG_W-1:0] bias_v;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: 3x3 frame, extreme weights and pixels, an ignored index
        // and a weight reload in the middle of the frame
        configure(3, 3, CFG_W'(5));
        for (int i = 0; i < KR * KC; i++) begin
            push_req(OP_WEIGHT, 16'sh0, WIDX_W'(i), (i % 2) ? 16'sh7FFF : 16'sh8000);
        end
        push_req(OP_WEIGHT, 16'shFFFF, 4'hF, 16'sh1234);
        for (int i = 0; i < KR * KC; i++) begin
            if (i == 4) push_req(OP_WEIGHT, 16'sh7FFF, 4'd4, 16'sh7FFF);
            push_req(OP_PIXEL, (i % 2) ? 16'sh7FFF : 16'sh8000, 4'hA, 16'sh5555);
        end
        drain(PHASE_PAD);

        // Widest row: rows below range clamp up, full frame fills the line store
        idle_on <= 1'b1;
        configure(2, 256, {CFG_W{1'b1}});
        queue_pixels(KR * 256, 40);
        drain(PHASE_PAD);

        // Tallest image from an oversized row count, narrow rows clamp up;
        // the long receiver hold-off lands in this phase
        configure(511, 0, pick_bias());
        stall_arm <= 1'b1;
        queue_pixels(256 * KC, 40);
        drain(PHASE_PAD);

        // Small random sizes; frames left unfinished carry over into new sizes
        for (int k = 0; k < 8; k++) begin
            bias_v = (k == 0) ? RES_MAX : (k == 1) ? RES_MIN : pick_bias();
            idle_on <= (k != 3);
            configure($urandom_range(0, 12), $urandom_range(0, 12), bias_v);
            queue_pixels($urandom_range(20, 70), 8);
            drain(PHASE_PAD);
        end

        // Closing stretch with no idling on either side
        idle_on <= 1'b0;
        configure($urandom_range(3, 9), $urandom_range(3, 9), pick_bias());
        queue_pixels(60, 8);
        drain(END_PAD);

        $display("Checked %0d window sums (%0d frame ends, %0d saturated) from %0d pixels",
                 n_results, n_frames, n_saturated, n_pixels);
        $display("and %0d weight loads over %0d size/bias settings, with stalls on both sides",
                 n_loads, n_settings);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
